### hdl/bss_pkg.sv
// package: types, constants and state codes of the block summary statistics block
package bss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 4096;
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
    localparam int SQ_W        = 2 * SAMPLE_BITS - 1 + COUNT_W - 1;
    localparam int NUM_W       = COUNT_W + SQ_W;
    localparam int DEN_W       = 24;
    localparam int DIV_W       = NUM_W + 16;
    localparam int RAD_W       = 48;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int TIME_W      = 40;
    localparam int Q_DEPTH     = 2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
        logic [TIME_W-1:0]             start_time;
        logic [TIME_W-1:0]             stop_time;
    } t_in;

    typedef struct packed {
        logic [15:0]        value_range;
        logic signed [23:0] mean_q8;
        logic [23:0]        deviation_q8;
        logic [TIME_W-1:0]  duration;
        logic [12:0]        sample_count;
        logic               overflow;
    } t_out;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
        logic [COUNT_W-1:0]      count;
        logic [15:0]             value_range;
        logic [TIME_W-1:0]       duration;
        logic                    overflow;
    } t_summ;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_MEAN,
        BK_VAR,
        BK_ROOT,
        BK_DONE
    } t_back_state;

endpackage

### hdl/block_summary_statistics.sv
// top level of the block summary statistics block
//
// input queue side: drive i_data and raise push; a transaction completes on a clock
// edge with push high and full low. one sample per cycle is taken while full is low.
// the sample marked last closes the block; the front part hands the block's totals,
// range and duration to a two-entry queue and clears its running state at once.
// output queue side: while empty is low, o_data holds the oldest result; it is
// taken on an edge with pop high. each block yields exactly one result.
// the result reaches the ports after two passes of the shared bit-serial divider
// (mean, then variance) and the bit-pair square root, with a multiply step before
// them and a hand-over step after. a block of one sample skips the variance pass and
// the root. the back part takes a new summary only once the last result is in the
// result register, which limits the rate at which blocks can close; full rises once
// two summaries are waiting.
// a stalled receiver holds the result register; the back part then waits, the
// queue fills and full rises only after that.
// reset (i_rst_n low at a clock edge) clears the running state, the queue and the
// result valid flag; no result is pending afterwards.
module block_summary_statistics import bss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    input  t_in  i_data,
    output logic full,
    input  logic pop,
    output t_out o_data,
    output logic empty
);

    logic  q_push, q_full, q_pop, q_empty, out_valid;
    t_summ q_wr_data, q_rd_data;

    bss_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (i_data),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_data (q_wr_data),
        .i_q_full (q_full)
    );

    bss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_data),
        .o_empty (q_empty)
    );

    bss_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_q_pop   (q_pop),
        .i_q_data  (q_rd_data),
        .i_q_empty (q_empty),
        .o_data    (o_data),
        .o_valid   (out_valid),
        .i_pop     (pop)
    );

    assign empty = !out_valid;

endmodule

### hdl/bss_front.sv
// front part: accepts samples and keeps the running count, sums, minimum and maximum
module bss_front import bss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_in   i_data,
    output logic  o_full,
    output logic  o_q_push,
    output t_summ o_q_data,
    input  logic  i_q_full
);

    logic [COUNT_W-1:0]            r_count, n_count;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [SQ_W-1:0]               r_sumsq, n_sumsq;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min, r_max, n_max;
    logic                          r_ovf, n_ovf;
    logic                          accept, take, first;
    logic signed [2*SAMPLE_BITS-1:0] square;

    assign accept = i_push && !i_q_full;
    assign take   = r_count < COUNT_W'(MAX_SAMPLES);
    assign first  = r_count == '0;
    assign square = i_data.sample * i_data.sample;

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sumsq = r_sumsq;
        n_min   = r_min;
        n_max   = r_max;
        n_ovf   = r_ovf;
        if (take) begin
            n_count = r_count + COUNT_W'(1);
            n_sum   = r_sum + SUM_W'(i_data.sample);
            n_sumsq = r_sumsq + SQ_W'(square[2*SAMPLE_BITS-2:0]);
            n_min   = (first || i_data.sample < r_min) ? i_data.sample : r_min;
            n_max   = (first || i_data.sample > r_max) ? i_data.sample : r_max;
        end else begin
            n_ovf = 1'b1;
        end
    end

    always_comb begin
        o_q_data.sum         = n_sum;
        o_q_data.sumsq       = n_sumsq;
        o_q_data.count       = n_count;
        o_q_data.value_range = 16'(n_max - n_min);
        o_q_data.duration    = (i_data.stop_time > i_data.start_time)
                               ? i_data.stop_time - i_data.start_time : '0;
        o_q_data.overflow    = n_ovf;
    end

    assign o_q_push = accept && i_data.last;
    assign o_full   = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_q_push) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sumsq <= n_sumsq;
            r_min   <= n_min;
            r_max   <= n_max;
            r_ovf   <= n_ovf;
        end
    end

endmodule

### hdl/bss_queue.sv
// short queue of block summaries between the front and back parts
module bss_queue import bss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_summ i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_summ o_data,
    output logic  o_empty
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_summ             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push, do_pop;

    assign o_full  = r_cnt == CNT_W'(Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hdl/bss_div.sv
// restoring divider, one quotient bit per cycle
module bss_div import bss_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy, r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_dq;
    logic [DEN_W-1:0] r_rem, r_dvs;
    logic [DEN_W:0]   rem_sh;
    logic             fits;

    assign rem_sh = {r_rem, r_dq[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DIV_W-2:0], fits};
            r_rem <= fits ? DEN_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dq;
    assign o_rem  = r_rem;

endmodule

### hdl/bss_back.sv
// back part: mean, variance and square root of one block summary, with the result register
module bss_back import bss_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    output logic  o_q_pop,
    input  t_summ i_q_data,
    input  logic  i_q_empty,
    output t_out  o_data,
    output logic  o_valid,
    input  logic  i_pop
);

    t_back_state          r_state, n_state;
    t_summ                r_summ;
    logic [NUM_W-1:0]     r_prod_a, r_prod_b, r_num;
    logic [DEN_W-1:0]     r_den;
    logic [23:0]          r_mean;
    logic [RAD_W-1:0]     r_rad;
    logic [ROOT_W-1:0]    r_root;
    logic [ROOT_W+1:0]    r_rem;
    logic [4:0]           r_step;
    t_out                 r_out;
    logic                 r_out_valid;

    logic                 out_free, out_load, multi;
    logic [SUM_W-1:0]     abs_sum;
    logic                 div_start, div_done;
    logic [DIV_W-1:0]     div_dividend, div_quot;
    logic [DEN_W-1:0]     div_divisor, div_rem;
    logic [23:0]          q24;
    logic [ROOT_W+3:0]    rem_sh, trial;
    logic                 root_fits;

    assign abs_sum  = r_summ.sum[SUM_W-1] ? SUM_W'(-r_summ.sum) : SUM_W'(r_summ.sum);
    assign multi    = r_summ.count > COUNT_W'(1);
    assign out_free = !r_out_valid || i_pop;
    assign q24      = div_quot[23:0];
    assign rem_sh   = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial    = {2'b00, r_root, 2'b01};
    assign root_fits = rem_sh >= trial;

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (!i_q_empty) n_state = BK_MUL;
            BK_MUL:  n_state = BK_MEAN;
            BK_MEAN: if (div_done) n_state = multi ? BK_VAR : BK_DONE;
            BK_VAR:  if (div_done) n_state = BK_ROOT;
            BK_ROOT: if (r_step == 5'(ROOT_W - 1)) n_state = BK_DONE;
            BK_DONE: if (out_free) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop      = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        div_dividend = {r_num, 16'b0};
        div_divisor  = r_den;
        case (r_state)
            BK_IDLE: o_q_pop = !i_q_empty;
            BK_MUL: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({abs_sum, 8'b0});
                div_divisor  = DEN_W'(r_summ.count);
            end
            BK_MEAN: div_start = div_done && multi;
            BK_DONE: out_load  = out_free;
            default: ;
        endcase
    end

    bss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == BK_ROOT) begin
                r_step <= r_step + 5'd1;
            end else begin
                r_step <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_summ <= i_q_data;
        end
        if (r_state == BK_MUL) begin
            r_prod_a <= NUM_W'(r_summ.count * r_summ.sumsq);
            r_prod_b <= NUM_W'(abs_sum * abs_sum);
            r_den    <= DEN_W'(r_summ.count * (r_summ.count - COUNT_W'(1)));
        end
        if (r_state == BK_MEAN) begin
            r_num <= r_prod_a - r_prod_b;
            if (div_done) begin
                r_mean <= r_summ.sum[SUM_W-1] ? 24'(-(q24 + 24'(div_rem != '0))) : q24;
                r_root <= '0;
                r_rem  <= '0;
            end
        end
        if (r_state == BK_VAR && div_done) begin
            r_rad  <= div_quot[RAD_W-1:0];
            r_root <= '0;
            r_rem  <= '0;
        end
        if (r_state == BK_ROOT) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= root_fits ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
            r_root <= {r_root[ROOT_W-2:0], root_fits};
        end
        if (out_load) begin
            r_out.value_range  <= r_summ.value_range;
            r_out.mean_q8      <= r_mean;
            r_out.deviation_q8 <= r_root;
            r_out.duration     <= r_summ.duration;
            r_out.sample_count <= r_summ.count;
            r_out.overflow     <= r_summ.overflow;
        end
    end

    assign o_data  = r_out;
    assign o_valid = r_out_valid;

endmodule

### hdl/bss_assert.sv
// port-level assertions for the block summary statistics block, with bind
module bss_assert import bss_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic pop,
    input t_out o_data,
    input logic empty
);

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending right after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data)))
        else $error("waiting result changed or vanished");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_data.sample_count != 13'd0 &&
                    o_data.sample_count <= 13'(MAX_SAMPLES)))
        else $error("sample count out of range");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.overflow) |-> o_data.sample_count == 13'(MAX_SAMPLES))
        else $error("overflow flagged on a block that is not full");

    a_single_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_data.sample_count == 13'd1) |->
            (o_data.deviation_q8 == 24'd0 && o_data.value_range == 16'd0))
        else $error("single-sample block with non-zero spread");

endmodule

bind block_summary_statistics bss_assert u_bss_assert (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .pop     (pop),
    .o_data  (o_data),
    .empty   (empty)
);

### tb/block_summary_statistics_tb.sv
// testbench for block_summary_statistics: directed and random sample blocks checked by a scoreboard
module block_summary_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    localparam int RANDOM_ITEMS    = 1150;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 800;
    localparam int HOLD_AT_RESULT  = 25;
    localparam int DRAIN_AT_BLOCK  = 50;
    localparam int TAIL_CYCLES     = 400;
    localparam int MAX_REPORTS     = 10;

    typedef enum {BLK_RANDOM, BLK_FIXED, BLK_ALTERNATE} t_block_kind;

    class stats_scoreboard;
        int unsigned     n_kept;
        longint          sum_acc;
        longint unsigned sq_acc;
        int              lo;
        int              hi;
        bit              dropped;
        t_out            expected_q[$];
        int              failures;

        function new();
            failures = 0;
            clear_block();
        endfunction

        function void clear_block();
            n_kept  = 0;
            sum_acc = 0;
            sq_acc  = 0;
            lo      = 0;
            hi      = 0;
            dropped = 0;
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned r;
            longint unsigned trial;
            r = 0;
            for (int b = 31; b >= 0; b--) begin
                trial = r | (64'd1 << b);
                if (trial * trial <= v) r = trial;
            end
            return r;
        endfunction

        // accumulate one accepted sample; a last sample closes the block
        function void note_sample(t_in item);
            int              s;
            longint          q_mean;
            longint          nl;
            longint unsigned nu;
            longint unsigned mag;
            longint unsigned num;
            longint unsigned den;
            longint unsigned quo;
            longint unsigned rem;
            t_out            res;
            s = $signed(item.sample);
            if (n_kept < MAX_SAMPLES) begin
                if (n_kept == 0) begin
                    lo = s;
                    hi = s;
                end else begin
                    if (s < lo) lo = s;
                    if (s > hi) hi = s;
                end
                sum_acc += s;
                sq_acc  += longint'(s * s);
                n_kept++;
            end else begin
                dropped = 1;
            end
            if (!item.last) return;
            res = '0;
            nl  = n_kept;
            nu  = n_kept;
            if (n_kept > 0) begin
                q_mean = sum_acc * 256;
                if (q_mean >= 0) q_mean = q_mean / nl;
                else q_mean = -((-q_mean + nl - 1) / nl);
                res.mean_q8 = q_mean[23:0];
            end
            if (n_kept > 1) begin
                mag = (sum_acc < 0) ? -sum_acc : sum_acc;
                num = nu * sq_acc - mag * mag;
                den = nu * (nu - 1);
                quo = num / den;
                rem = num % den;
                quo = quo * 65536 + (rem * 65536) / den;
                quo = floor_root(quo);
                res.deviation_q8 = quo[23:0];
            end
            res.value_range  = 16'(hi - lo);
            res.duration     = (item.stop_time > item.start_time) ?
                               item.stop_time - item.start_time : '0;
            res.sample_count = 13'(n_kept);
            res.overflow     = dropped;
            expected_q = {expected_q, res};
            clear_block();
        endfunction

        function void log_failure(string what, t_out want, t_out got);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%s: expected range %0d mean %0d dev %0d dur %0d n %0d ovf %0d",
                         what, want.value_range, $signed(want.mean_q8), want.deviation_q8,
                         want.duration, want.sample_count, want.overflow);
                $display("    actual   range %0d mean %0d dev %0d dur %0d n %0d ovf %0d",
                         got.value_range, $signed(got.mean_q8), got.deviation_q8,
                         got.duration, got.sample_count, got.overflow);
            end
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_q.size() == 0) begin
                log_failure("unexpected transaction", '0, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.value_range !== want.value_range || got.mean_q8 !== want.mean_q8 ||
                got.deviation_q8 !== want.deviation_q8 || got.duration !== want.duration ||
                got.sample_count !== want.sample_count || got.overflow !== want.overflow)
                log_failure("mismatch", want, got);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_data  = '0;
    logic full;
    logic empty;
    t_out o_data;

    stats_scoreboard stats_sb;
    bit              send_gapless = 1'b0;
    int              results_taken = 0;

    block_summary_statistics u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_data  (i_data),
        .full    (full),
        .pop     (pop),
        .o_data  (o_data),
        .empty   (empty)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2, 3:    return 16'($urandom_range(0, 200) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return TIME_W'({$urandom, $urandom});
        endcase
    endfunction

    task automatic send_sample(input t_in item);
        int gap;
        gap = send_gapless ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push   <= 1'b1;
        i_data <= item;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        stats_sb.note_sample(item);
    endtask

    task automatic send_block(input int len, input t_block_kind kind, input logic [15:0] value,
                              input logic [TIME_W-1:0] t_start,
                              input logic [TIME_W-1:0] t_stop);
        t_in item;
        for (int k = 0; k < len; k++) begin
            case (kind)
                BLK_FIXED:     item.sample = value;
                BLK_ALTERNATE: item.sample = k[0] ? ~value : value;
                default:       item.sample = pick_sample();
            endcase
            item.last       = (k == len - 1);
            item.start_time = item.last ? t_start : pick_time();
            item.stop_time  = item.last ? t_stop : pick_time();
            send_sample(item);
        end
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (stats_sb.pending() != 0) @(posedge i_clk);
    endtask

    // result side
    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = ((results_taken / 10) % 3 == 0) ? 0 : $urandom_range(0, 7);
            if (results_taken == HOLD_AT_RESULT) gap = HOLD_OFF_CYCLES;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            stats_sb.check_result(o_data);
            results_taken++;
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (push && !full) || (pop && !empty)) quiet = 0;
            else quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int                pick;
        int                len;
        int                blocks;
        int                random_sent;
        logic [TIME_W-1:0] t_start;
        logic [TIME_W-1:0] t_stop;
        stats_sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_block(1, BLK_FIXED, 16'h7fff, '0, '1);
        send_block(1, BLK_FIXED, 16'h8000, 40'd5, 40'd3);
        send_block(2, BLK_ALTERNATE, 16'h8000, 40'd77, 40'd77);
        send_block(3, BLK_ALTERNATE, 16'hffff, 40'd1, 40'd2);
        send_block(2, BLK_FIXED, 16'h8000, '1, '0);
        send_block(5, BLK_RANDOM, '0, pick_time(), pick_time());
        wait_for_results();

        random_sent = 0;
        blocks      = 0;
        while (random_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) len = $urandom_range(1, 8);
            else if (pick < 97) len = $urandom_range(9, 40);
            else len = $urandom_range(41, 200);
            send_gapless = ($urandom_range(0, 4) == 0);
            t_start = pick_time();
            case ($urandom_range(0, 3))
                0:       t_stop = t_start;
                1:       t_stop = t_start + TIME_W'($urandom_range(1, 1000));
                default: t_stop = pick_time();
            endcase
            send_block(len, BLK_RANDOM, '0, t_start, t_stop);
            random_sent += len;
            blocks++;
            if (blocks == DRAIN_AT_BLOCK) wait_for_results();
        end

        push <= 1'b0;
        while (stats_sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (stats_sb.failures == 0 && stats_sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
hdl/bss_pkg.sv
hdl/bss_front.sv
hdl/bss_queue.sv
hdl/bss_div.sv
hdl/bss_back.sv
hdl/block_summary_statistics.sv
hdl/bss_assert.sv
tb/block_summary_statistics_tb.sv
